>>> hw/rtl/slex_pkg.sv
// ----------------------------------------------------------------------------
// slex_pkg
// Types and constants shared by the script lexer modules.
// ----------------------------------------------------------------------------
package slex_pkg;

   localparam int unsigned MaxTextBytes = 65536;
   localparam int unsigned PosW = $clog2(MaxTextBytes) + 1;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      logic [4:0]  token_kind;
      logic [15:0] token_offset;
      logic [16:0] token_length;
      logic [2:0]  error_code;
      logic        end_of_text;
      logic        run_last;
   } rsp_type;

   typedef enum logic [3:0] {
      M_IDLE, M_EQ, M_SPACES, M_NEWLINES, M_STRING, M_FIELD, M_TEXT,
      M_NUMBER, M_COMMENT, M_DRAIN
   } mode_type;

   localparam logic [4:0] K_EQUAL    = 5'd8;
   localparam logic [4:0] K_ASSIGN   = 5'd9;
   localparam logic [4:0] K_KEYWORD0 = 5'd10;
   localparam logic [4:0] K_SPACES   = 5'd16;
   localparam logic [4:0] K_NEWLINES = 5'd17;
   localparam logic [4:0] K_STRING   = 5'd18;
   localparam logic [4:0] K_FIELD    = 5'd19;
   localparam logic [4:0] K_TEXT     = 5'd20;
   localparam logic [4:0] K_NUMBER   = 5'd21;
   localparam logic [4:0] K_COMMENT  = 5'd22;

   localparam logic [2:0] E_OK       = 3'd0;
   localparam logic [2:0] E_BAD_CHAR = 3'd1;
   localparam logic [2:0] E_UNPRINT  = 3'd2;
   localparam logic [2:0] E_NO_SPACE = 3'd3;
   localparam logic [2:0] E_NO_TEXT  = 3'd4;
   localparam logic [2:0] E_TRAILING = 3'd5;
   localparam logic [2:0] E_TOO_LONG = 3'd6;

   // up to two results per request
   typedef struct packed {
      logic    two;
      rsp_type first;
      rsp_type second;
   } pair_type;

   function automatic logic [4:0] punct_kind(input logic [7:0] c);
      case (c)
         8'h28:   punct_kind = 5'd0;
         8'h29:   punct_kind = 5'd1;
         8'h7b:   punct_kind = 5'd2;
         8'h7d:   punct_kind = 5'd3;
         8'h2b:   punct_kind = 5'd4;
         8'h2d:   punct_kind = 5'd5;
         8'h2c:   punct_kind = 5'd6;
         default: punct_kind = 5'd7;
      endcase
   endfunction

   function automatic logic is_punct(input logic [7:0] c);
      is_punct = (c == 8'h28) || (c == 8'h29) || (c == 8'h7b) || (c == 8'h7d) ||
                 (c == 8'h2b) || (c == 8'h2d) || (c == 8'h2c) || (c == 8'h3a);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      is_alpha = (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      is_digit = c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic is_word(input logic [7:0] c);
      is_word = is_alpha(c) || is_digit(c) || c == 8'h5f || c == 8'h2e;
   endfunction

   // keyword letter at index k, zero past the end
   function automatic logic [7:0] kw_char(input logic [2:0] w, input logic [3:0] k);
      logic [63:0] s;
      logic [2:0]  kk;
      s = 64'd0;
      case (w)
         3'd0:    s = {"if", 48'd0};
         3'd1:    s = {"else", 32'd0};
         3'd2:    s = {"loop", 32'd0};
         3'd3:    s = {"break", 24'd0};
         3'd4:    s = {"return", 16'd0};
         default: s = "continue";
      endcase
      kk = k[2:0];
      kw_char = k[3] ? 8'd0 : s[63 - 8*kk -: 8];
   endfunction

   function automatic logic [3:0] kw_len(input logic [2:0] w);
      case (w)
         3'd0:    kw_len = 4'd2;
         3'd1:    kw_len = 4'd4;
         3'd2:    kw_len = 4'd4;
         3'd3:    kw_len = 4'd5;
         3'd4:    kw_len = 4'd6;
         default: kw_len = 4'd8;
      endcase
   endfunction

endpackage

>>> hw/rtl/script_lexer_top.sv
// ----------------------------------------------------------------------------
// script_lexer_top
// Script text lexer: one byte per request, token results out.
// ----------------------------------------------------------------------------
// channel  direction  payload                 handshake
// req      in         slex_pkg::req_type      req_valid / req_ready
// rsp      out        slex_pkg::rsp_type      rsp_valid / rsp_ready
//
// one request per cycle while the queue has room; the scanner state updates in the accepting cycle
// the first result is registered in the queue, then offered once the pairs ahead of it are sent
// a request yielding two results sends them in turn, each as the rsp port takes it
// a four-pair queue lets the scanner run ahead while rsp stalls
// reset is synchronous, clears the scanner and queue; no clearing pass
module script_lexer_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  slex_pkg::req_type req,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output slex_pkg::rsp_type rsp
);

   slex_pkg::pair_type sc_pair, q_pair;
   logic sc_valid, q_room, q_valid, q_pop, take;

   assign req_ready = q_room;
   assign take      = req_valid && req_ready;

   slex_scan u_scan (
      .clock(clock), .reset(reset), .take(take), .req(req),
      .pair(sc_pair), .pair_valid(sc_valid)
   );

   slex_queue u_queue (
      .clock(clock), .reset(reset), .push(sc_valid), .push_data(sc_pair),
      .room(q_room), .pop_valid(q_valid), .pop_data(q_pair), .pop(q_pop)
   );

   slex_emit u_emit (
      .clock(clock), .reset(reset), .pair_valid(q_valid), .pair(q_pair),
      .pair_pop(q_pop), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
   );

endmodule

>>> hw/rtl/slex_scan.sv
// ----------------------------------------------------------------------------
// slex_scan
// Front end: classifies each request byte and builds the token results.
// ----------------------------------------------------------------------------
module slex_scan (
   input  logic               clock,
   input  logic               reset,
   input  logic               take,
   input  slex_pkg::req_type  req,
   output slex_pkg::pair_type pair,
   output logic               pair_valid
);

   localparam int unsigned PW = slex_pkg::PosW;

   slex_pkg::mode_type mode_ff, mode_in;
   logic [PW-1:0] begin_ff, begin_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [5:0]    cand_ff, cand_in;
   logic [1:0]    chk_ff, chk_in;
   logic [7:0]    prev_ff, prev_in;

   slex_pkg::rsp_type r0, r1;
   logic [1:0] nres;
   logic       ended;

   logic [PW-1:0] tlen;
   logic [7:0]    c;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= slex_pkg::M_IDLE;
         begin_ff <= '0;
         pos_ff   <= '0;
         cand_ff  <= '0;
         chk_ff   <= '0;
         prev_ff  <= '0;
      end else if (take) begin
         mode_ff  <= mode_in;
         begin_ff <= begin_in;
         pos_ff   <= pos_in;
         cand_ff  <= cand_in;
         chk_ff   <= chk_in;
         prev_ff  <= prev_in;
      end
   end

   function automatic slex_pkg::rsp_type mk(input logic [4:0] k, input logic [PW-1:0] off,
                                            input logic [PW-1:0] len, input logic [2:0] e);
      slex_pkg::rsp_type r;
      r.token_kind   = k;
      r.token_offset = (off > PW'(16'hffff)) ? 16'hffff : off[15:0];
      r.token_length = (len > PW'(17'h1ffff)) ? 17'h1ffff : 17'(len);
      r.error_code   = e;
      r.end_of_text  = 1'b0;
      r.run_last     = 1'b0;
      return r;
   endfunction

   always_comb begin
      slex_pkg::rsp_type cr;
      logic    cl_has, cl_err, do_close, do_start, st_has, st_err, nsp, fed_err;
      logic [4:0] kwk;
      logic [3:0] tl4;
      mode_type_dummy: begin end
      c = req.text_byte;
      tlen = pos_ff - begin_ff;
      tl4 = (tlen > PW'(15)) ? 4'd15 : tlen[3:0];
      mode_in  = mode_ff;
      begin_in = begin_ff;
      pos_in   = pos_ff;
      cand_in  = cand_ff;
      chk_in   = chk_ff;
      prev_in  = prev_ff;
      r0 = '0;
      r1 = '0;
      nres = 2'd0;
      ended = 1'b0;
      cl_has = 1'b0; cl_err = 1'b0; cr = '0;
      do_close = 1'b0; do_start = 1'b0; st_has = 1'b0; st_err = 1'b0;
      fed_err = 1'b0;
      nsp = 1'b0;
      kwk = slex_pkg::K_TEXT;
      pair = '0;

      // close result for the open token (ending before pos_ff)
      for (int i = 0; i < 6; i++)
         if (cand_ff[i] && slex_pkg::kw_len(3'(i)) == tl4 && tlen < PW'(9))
            kwk = slex_pkg::K_KEYWORD0 + 5'(i);

      if (mode_ff == slex_pkg::M_DRAIN) begin
         if (req.final_byte) begin
            mode_in = slex_pkg::M_IDLE; begin_in = '0; pos_in = '0;
            cand_in = '0; chk_in = '0; prev_in = '0;
         end
      end else begin
         nsp = (c == 8'h20) && (c != 8'd0);
         // close-token evaluation (nsp only applies for feed path)
         unique case (mode_ff)
            slex_pkg::M_EQ:       begin cl_has = 1'b1;
               cr = mk(slex_pkg::K_ASSIGN, begin_ff, PW'(1), slex_pkg::E_OK); end
            slex_pkg::M_SPACES:   begin cl_has = 1'b1;
               cr = mk(slex_pkg::K_SPACES, begin_ff, tlen, slex_pkg::E_OK); end
            slex_pkg::M_NEWLINES: begin cl_has = 1'b1;
               cr = mk(slex_pkg::K_NEWLINES, begin_ff, tlen, slex_pkg::E_OK); end
            slex_pkg::M_STRING:   begin cl_has = 1'b1;
               cr = mk(slex_pkg::K_STRING, begin_ff, tlen, slex_pkg::E_OK); end
            slex_pkg::M_FIELD:    begin cl_has = 1'b1;
               cr = mk(slex_pkg::K_FIELD, begin_ff, tlen, slex_pkg::E_OK); end
            slex_pkg::M_NUMBER:   begin cl_has = 1'b1;
               cr = mk(slex_pkg::K_NUMBER, begin_ff, tlen, slex_pkg::E_OK); end
            slex_pkg::M_TEXT:     begin cl_has = 1'b1;
               cr = mk(nsp ? kwk : slex_pkg::K_TEXT, begin_ff, tlen, slex_pkg::E_OK); end
            slex_pkg::M_COMMENT:  begin
               cl_has = 1'b1; cl_err = 1'b1;
               if (tlen < PW'(2) || !chk_ff[0])
                  cr = mk(5'd0, begin_ff + PW'(1), '0, slex_pkg::E_NO_SPACE);
               else if (tlen < PW'(3) || !chk_ff[1])
                  cr = mk(5'd0, begin_ff + PW'(2), '0, slex_pkg::E_NO_TEXT);
               else if (prev_ff == 8'h20)
                  cr = mk(5'd0, pos_ff - PW'(1), '0, slex_pkg::E_TRAILING);
               else begin
                  cl_err = 1'b0;
                  cr = mk(slex_pkg::K_COMMENT, begin_ff, tlen, slex_pkg::E_OK);
               end
            end
            default: ;
         endcase

         if (c == 8'd0) begin
            // end of text: text-kind closes never see a following space
            if (mode_ff == slex_pkg::M_TEXT)
               cr = mk(slex_pkg::K_TEXT, begin_ff, tlen, slex_pkg::E_OK);
            if (cl_has) begin r0 = cr; nres = 2'd1; end
            ended = 1'b1;
         end else if (pos_ff >= PW'(slex_pkg::MaxTextBytes)) begin
            r0 = mk(5'd0, pos_ff, '0, slex_pkg::E_TOO_LONG);
            nres = 2'd1;
            ended = 1'b1;
         end else begin
            // feed
            unique case (mode_ff)
               slex_pkg::M_EQ: begin
                  if (c == 8'h3d) begin
                     r0 = mk(slex_pkg::K_EQUAL, begin_ff, PW'(2), slex_pkg::E_OK);
                     nres = 2'd1; mode_in = slex_pkg::M_IDLE;
                  end else do_close = 1'b1;
               end
               slex_pkg::M_SPACES:   do_close = (c != 8'h20);
               slex_pkg::M_NEWLINES: do_close = (c != 8'h0a);
               slex_pkg::M_STRING: begin
                  if (c == 8'h22) begin
                     r0 = mk(slex_pkg::K_STRING, begin_ff, tlen + PW'(1), slex_pkg::E_OK);
                     nres = 2'd1; mode_in = slex_pkg::M_IDLE;
                  end
               end
               slex_pkg::M_FIELD:  do_close = !slex_pkg::is_word(c);
               slex_pkg::M_NUMBER: do_close = !(slex_pkg::is_digit(c) || c == 8'h2e);
               slex_pkg::M_TEXT: begin
                  if (slex_pkg::is_word(c)) begin
                     for (int i = 0; i < 6; i++)
                        if (tlen >= PW'(slex_pkg::kw_len(3'(i))) ||
                            slex_pkg::kw_char(3'(i), tl4) != c)
                           cand_in[i] = 1'b0;
                  end else do_close = 1'b1;
               end
               slex_pkg::M_COMMENT: begin
                  if (c >= 8'h20 && c <= 8'h7e) begin
                     if (tlen == PW'(1) && c == 8'h20) chk_in[0] = 1'b1;
                     if (tlen == PW'(2) && c != 8'h20) chk_in[1] = 1'b1;
                  end else if (c != 8'h0a) begin
                     r0 = mk(5'd0, pos_ff, '0, slex_pkg::E_UNPRINT);
                     nres = 2'd1; fed_err = 1'b1;
                  end else do_close = 1'b1;
               end
               default: do_start = 1'b1;
            endcase

            if (do_close) begin
               mode_in = slex_pkg::M_IDLE;
               if (cl_has) begin r0 = cr; nres = 2'd1; end
               if (cl_err) fed_err = 1'b1;
               else do_start = 1'b1;
            end

            if (do_start) begin
               begin_in = pos_ff;
               st_has = 1'b0;
               st_err = 1'b0;
               if (slex_pkg::is_punct(c)) begin
                  st_has = 1'b1;
                  cr = mk(slex_pkg::punct_kind(c), pos_ff, PW'(1), slex_pkg::E_OK);
                  mode_in = slex_pkg::M_IDLE;
               end else if (c == 8'h3d) mode_in = slex_pkg::M_EQ;
               else if (c == 8'h20) mode_in = slex_pkg::M_SPACES;
               else if (c == 8'h0a) mode_in = slex_pkg::M_NEWLINES;
               else if (c == 8'h22) mode_in = slex_pkg::M_STRING;
               else if (c == 8'h2e) mode_in = slex_pkg::M_FIELD;
               else if (c == 8'h3b) begin
                  mode_in = slex_pkg::M_COMMENT; chk_in = '0;
               end else if (slex_pkg::is_alpha(c) || c == 8'h5f) begin
                  mode_in = slex_pkg::M_TEXT;
                  for (int i = 0; i < 6; i++)
                     cand_in[i] = (slex_pkg::kw_char(3'(i), 4'd0) == c);
               end else if (slex_pkg::is_digit(c)) mode_in = slex_pkg::M_NUMBER;
               else begin
                  st_has = 1'b1; st_err = 1'b1;
                  cr = mk(5'd0, pos_ff, '0, slex_pkg::E_BAD_CHAR);
                  mode_in = slex_pkg::M_IDLE;
               end
               if (st_has) begin
                  if (nres == 2'd0) r0 = cr; else r1 = cr;
                  nres = nres + 2'd1;
               end
               if (st_err) fed_err = 1'b1;
            end

            prev_in = c;
            pos_in = pos_ff + PW'(1);

            if (fed_err) ended = 1'b1;
            else if (req.final_byte) begin
               // close whatever is open after this byte, at pos+1
               ended = 1'b1;
               unique case (mode_in)
                  slex_pkg::M_EQ: cr = mk(slex_pkg::K_ASSIGN, begin_in, PW'(1), slex_pkg::E_OK);
                  slex_pkg::M_SPACES: cr = mk(slex_pkg::K_SPACES, begin_in,
                                              pos_in - begin_in, slex_pkg::E_OK);
                  slex_pkg::M_NEWLINES: cr = mk(slex_pkg::K_NEWLINES, begin_in,
                                                pos_in - begin_in, slex_pkg::E_OK);
                  slex_pkg::M_STRING: cr = mk(slex_pkg::K_STRING, begin_in,
                                              pos_in - begin_in, slex_pkg::E_OK);
                  slex_pkg::M_FIELD: cr = mk(slex_pkg::K_FIELD, begin_in,
                                             pos_in - begin_in, slex_pkg::E_OK);
                  slex_pkg::M_NUMBER: cr = mk(slex_pkg::K_NUMBER, begin_in,
                                              pos_in - begin_in, slex_pkg::E_OK);
                  slex_pkg::M_TEXT: cr = mk(slex_pkg::K_TEXT, begin_in,
                                            pos_in - begin_in, slex_pkg::E_OK);
                  slex_pkg::M_COMMENT: begin
                     if (pos_in - begin_in < PW'(2) || !chk_in[0])
                        cr = mk(5'd0, begin_in + PW'(1), '0, slex_pkg::E_NO_SPACE);
                     else if (pos_in - begin_in < PW'(3) || !chk_in[1])
                        cr = mk(5'd0, begin_in + PW'(2), '0, slex_pkg::E_NO_TEXT);
                     else if (c == 8'h20)
                        cr = mk(5'd0, pos_ff, '0, slex_pkg::E_TRAILING);
                     else
                        cr = mk(slex_pkg::K_COMMENT, begin_in,
                                pos_in - begin_in, slex_pkg::E_OK);
                  end
                  default: cr = '0;
               endcase
               if (mode_in != slex_pkg::M_IDLE) begin
                  if (nres == 2'd0) r0 = cr; else r1 = cr;
                  nres = nres + 2'd1;
               end
            end
         end

         if (ended && nres == 2'd0) begin
            r0 = mk(5'd0, pos_in, '0, slex_pkg::E_OK);
            nres = 2'd1;
         end
         if (nres == 2'd2) begin
            r1.run_last = 1'b1; r1.end_of_text = ended;
         end else begin
            r0.run_last = 1'b1; r0.end_of_text = ended;
         end
         if (ended) begin
            if (req.final_byte) begin
               mode_in = slex_pkg::M_IDLE; begin_in = '0; pos_in = '0;
               cand_in = '0; chk_in = '0; prev_in = '0;
            end else mode_in = slex_pkg::M_DRAIN;
         end
      end
      pair.two    = (nres == 2'd2);
      pair.first  = r0;
      pair.second = r1;
   end

   assign pair_valid = take && (nres != 2'd0);

   assert property (@(posedge clock) disable iff (reset)
      (take && mode_ff == slex_pkg::M_DRAIN) |-> !pair_valid)
      else $error("result produced while draining");
   assert property (@(posedge clock) disable iff (reset)
      (take && !req.final_byte && pair_valid && (pair.two ? pair.second.end_of_text
                                                        : pair.first.end_of_text))
      |=> mode_ff == slex_pkg::M_DRAIN)
      else $error("no drain after end");
   assert property (@(posedge clock) disable iff (reset)
      pos_ff <= PW'(slex_pkg::MaxTextBytes))
      else $error("position ran past limit");

endmodule

>>> hw/rtl/slex_queue.sv
// ----------------------------------------------------------------------------
// slex_queue
// Small queue of result pairs between scanner and output stage.
// ----------------------------------------------------------------------------
module slex_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  slex_pkg::pair_type push_data,
   output logic               room,
   output logic               pop_valid,
   output slex_pkg::pair_type pop_data,
   input  logic               pop
);

   slex_pkg::pair_type slot_ff [4];
   logic [1:0] wr_ff, rd_ff;
   logic [2:0] cnt_ff;

   // push lands at the accepting edge, so one free slot is enough
   assign room      = cnt_ff != 3'd4;
   assign pop_valid = cnt_ff != 3'd0;
   assign pop_data  = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 2'd1;
         if (pop && pop_valid) rd_ff <= rd_ff + 2'd1;
         cnt_ff <= cnt_ff + 3'(push) - 3'(pop && pop_valid);
      end
   end

   assert property (@(posedge clock) disable iff (reset) push |-> cnt_ff != 3'd4)
      else $error("queue overflow");

endmodule

>>> hw/rtl/slex_emit.sv
// ----------------------------------------------------------------------------
// slex_emit
// Back end: sends the one or two results of each queued pair in order.
// ----------------------------------------------------------------------------
module slex_emit (
   input  logic               clock,
   input  logic               reset,
   input  logic               pair_valid,
   input  slex_pkg::pair_type pair,
   output logic               pair_pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output slex_pkg::rsp_type  rsp
);

   logic sec_ff, sec_in;

   assign rsp_valid = pair_valid;
   assign rsp       = sec_ff ? pair.second : pair.first;
   assign pair_pop  = rsp_valid && rsp_ready && (sec_ff || !pair.two);

   always_comb begin
      sec_in = sec_ff;
      if (rsp_valid && rsp_ready) sec_in = !sec_ff && pair.two;
   end

   always_ff @(posedge clock) begin
      if (reset) sec_ff <= 1'b0;
      else sec_ff <= sec_in;
   end

   assert property (@(posedge clock) disable iff (reset) sec_ff |-> pair_valid && pair.two)
      else $error("second half without a pair");

endmodule

>>> verif/tb_script_lexer_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_script_lexer_top
// Feeds the lexer short texts, one byte per request, and checks every token
// against a local scanner model kept in step with the accepted requests.
// ----------------------------------------------------------------------------
module tb_script_lexer_top;

   localparam int unsigned WatchdogLimit = 20000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   slex_pkg::req_type req = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   slex_pkg::rsp_type rsp;

   script_lexer_top u_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // scanner copy
   slex_pkg::mode_type lx_mode;
   int unsigned        lx_begin, lx_pos;
   logic [5:0]         lx_cand;
   logic [1:0]         lx_chk;
   logic [7:0]         lx_prev;
   slex_pkg::rsp_type  step_out[$];
   slex_pkg::rsp_type  token_queue[$];
   int                 fail_count = 0;
   int unsigned        idle_cycles = 0;

   // directed texts, the last byte of each flagged final
   string dir_texts[] = '{
      "( ) { } + - , :",
      "if x else y loop break return continue z",
      "a==b=c .f 3.1 \"q\"",
      "\"open",
      "; ok\n;x\n",
      ";  a\n",
      "; a \n",
      ";",
      "a\tb",
      "; a\x01b",
      "if"
   };

   // directed raw bytes: {text_byte, final_byte}
   logic [8:0] dir_bytes[] = '{
      {8'hff, 1'b1},
      {8'h00, 1'b0},
      {8'h71, 1'b1},
      {8'h00, 1'b1},
      {8'h61, 1'b0},
      {8'h62, 1'b0},
      {8'h00, 1'b0},
      {8'h63, 1'b0},
      {8'h64, 1'b1}
   };

   function automatic bit is_letter(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction
   function automatic bit is_num(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction
   function automatic bit is_wchar(logic [7:0] c);
      return is_letter(c) || is_num(c) || c == "_" || c == ".";
   endfunction
   function automatic string word_of(int w);
      case (w)
         0: return "if";
         1: return "else";
         2: return "loop";
         3: return "break";
         4: return "return";
         default: return "continue";
      endcase
   endfunction

   task automatic emit(logic [4:0] kind, int unsigned off, int unsigned len, logic [2:0] err);
      slex_pkg::rsp_type r;
      if (step_out.size() >= 2) return;
      r = '0;
      r.token_kind = kind;
      r.token_offset = off > 65535 ? 16'hffff : off[15:0];
      r.token_length = len > 131071 ? 17'h1ffff : len[16:0];
      r.error_code = err;
      step_out.push_back(r);
   endtask

   task automatic lex_restart();
      lx_mode = slex_pkg::M_IDLE; lx_begin = 0; lx_pos = 0;
      lx_cand = 0; lx_chk = 0; lx_prev = 0;
   endtask

   task automatic close_open(bit next_space, output bit err);
      int unsigned len;
      logic [4:0] kind;
      slex_pkg::mode_type m;
      len = lx_pos - lx_begin;
      kind = slex_pkg::K_TEXT;
      m = lx_mode;
      err = 0;
      lx_mode = slex_pkg::M_IDLE;
      case (m)
         slex_pkg::M_EQ:       emit(slex_pkg::K_ASSIGN, lx_begin, 1, slex_pkg::E_OK);
         slex_pkg::M_SPACES:   emit(slex_pkg::K_SPACES, lx_begin, len, slex_pkg::E_OK);
         slex_pkg::M_NEWLINES: emit(slex_pkg::K_NEWLINES, lx_begin, len, slex_pkg::E_OK);
         slex_pkg::M_STRING:   emit(slex_pkg::K_STRING, lx_begin, len, slex_pkg::E_OK);
         slex_pkg::M_FIELD:    emit(slex_pkg::K_FIELD, lx_begin, len, slex_pkg::E_OK);
         slex_pkg::M_NUMBER:   emit(slex_pkg::K_NUMBER, lx_begin, len, slex_pkg::E_OK);
         slex_pkg::M_TEXT: begin
            if (next_space)
               for (int i = 0; i < 6; i++)
                  if (lx_cand[i] && word_of(i).len() == len)
                     kind = slex_pkg::K_KEYWORD0 + 5'(i);
            emit(kind, lx_begin, len, slex_pkg::E_OK);
         end
         slex_pkg::M_COMMENT: begin
            err = 1;
            if (len < 2 || !lx_chk[0])
               emit(5'd0, lx_begin + 1, 0, slex_pkg::E_NO_SPACE);
            else if (len < 3 || !lx_chk[1])
               emit(5'd0, lx_begin + 2, 0, slex_pkg::E_NO_TEXT);
            else if (lx_prev == " ")
               emit(5'd0, lx_begin + len - 1, 0, slex_pkg::E_TRAILING);
            else begin
               err = 0;
               emit(slex_pkg::K_COMMENT, lx_begin, len, slex_pkg::E_OK);
            end
         end
         default: ;
      endcase
   endtask

   task automatic open_token(logic [7:0] c, output bit err);
      string w;
      err = 0;
      lx_begin = lx_pos;
      case (c)
         "(": emit(5'd0, lx_pos, 1, slex_pkg::E_OK);
         ")": emit(5'd1, lx_pos, 1, slex_pkg::E_OK);
         "{": emit(5'd2, lx_pos, 1, slex_pkg::E_OK);
         "}": emit(5'd3, lx_pos, 1, slex_pkg::E_OK);
         "+": emit(5'd4, lx_pos, 1, slex_pkg::E_OK);
         "-": emit(5'd5, lx_pos, 1, slex_pkg::E_OK);
         ",": emit(5'd6, lx_pos, 1, slex_pkg::E_OK);
         ":": emit(5'd7, lx_pos, 1, slex_pkg::E_OK);
         "=": lx_mode = slex_pkg::M_EQ;
         " ": lx_mode = slex_pkg::M_SPACES;
         8'h0a: lx_mode = slex_pkg::M_NEWLINES;
         8'h22: lx_mode = slex_pkg::M_STRING;
         ".": lx_mode = slex_pkg::M_FIELD;
         ";": begin
            lx_mode = slex_pkg::M_COMMENT;
            lx_chk = 0;
         end
         default: begin
            if (is_letter(c) || c == "_") begin
               lx_mode = slex_pkg::M_TEXT;
               lx_cand = 0;
               for (int i = 0; i < 6; i++) begin
                  w = word_of(i);
                  if (w[0] == c) lx_cand[i] = 1;
               end
            end else if (is_num(c)) lx_mode = slex_pkg::M_NUMBER;
            else begin
               emit(5'd0, lx_pos, 0, slex_pkg::E_BAD_CHAR);
               err = 1;
            end
         end
      endcase
   endtask

   task automatic scan_byte(logic [7:0] c, output bit err);
      int unsigned k;
      string w;
      bit closing;
      k = lx_pos - lx_begin;
      err = 0;
      closing = 1;
      case (lx_mode)
         slex_pkg::M_EQ: if (c == "=") begin
            emit(slex_pkg::K_EQUAL, lx_begin, 2, slex_pkg::E_OK);
            lx_mode = slex_pkg::M_IDLE;
            closing = 0;
         end
         slex_pkg::M_SPACES:   if (c == " ") closing = 0;
         slex_pkg::M_NEWLINES: if (c == 8'h0a) closing = 0;
         slex_pkg::M_STRING: begin
            if (c == 8'h22) begin
               emit(slex_pkg::K_STRING, lx_begin, k + 1, slex_pkg::E_OK);
               lx_mode = slex_pkg::M_IDLE;
            end
            closing = 0;
         end
         slex_pkg::M_FIELD:  if (is_wchar(c)) closing = 0;
         slex_pkg::M_NUMBER: if (is_num(c) || c == ".") closing = 0;
         slex_pkg::M_TEXT: if (is_wchar(c)) begin
            for (int i = 0; i < 6; i++) begin
               w = word_of(i);
               if (k >= w.len() || w[k] != c) lx_cand[i] = 0;
            end
            closing = 0;
         end
         slex_pkg::M_COMMENT: begin
            if (c >= 8'h20 && c <= 8'h7e) begin
               if (k == 1 && c == " ") lx_chk[0] = 1;
               if (k == 2 && c != " ") lx_chk[1] = 1;
               closing = 0;
            end else if (c != 8'h0a) begin
               emit(5'd0, lx_pos, 0, slex_pkg::E_UNPRINT);
               err = 1;
               closing = 0;
            end
         end
         default: begin
            open_token(c, err);
            closing = 0;
         end
      endcase
      if (closing) begin
         close_open(c == " ", err);
         if (!err) open_token(c, err);
      end
   endtask

   // expected tokens for one accepted request
   task automatic lex_request(slex_pkg::req_type r);
      bit ended, err;
      ended = 0;
      step_out.delete();
      if (lx_mode == slex_pkg::M_DRAIN) begin
         if (r.final_byte) lex_restart();
         return;
      end
      if (r.text_byte == 0) begin
         close_open(0, err);
         ended = 1;
      end else if (lx_pos >= slex_pkg::MaxTextBytes) begin
         emit(5'd0, lx_pos, 0, slex_pkg::E_TOO_LONG);
         ended = 1;
      end else begin
         scan_byte(r.text_byte, err);
         lx_prev = r.text_byte;
         lx_pos++;
         if (err) ended = 1;
         else if (r.final_byte) begin
            close_open(0, err);
            ended = 1;
         end
      end
      if (ended && step_out.size() == 0) emit(5'd0, lx_pos, 0, slex_pkg::E_OK);
      if (step_out.size() > 0) begin
         step_out[step_out.size()-1].run_last = 1;
         if (ended) step_out[step_out.size()-1].end_of_text = 1;
      end
      foreach (step_out[i]) token_queue.push_back(step_out[i]);
      if (ended) begin
         if (r.final_byte) lex_restart();
         else lx_mode = slex_pkg::M_DRAIN;
      end
   endtask

   // checker and watchdog
   always @(posedge clock) begin
      slex_pkg::rsp_type e;
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (req_valid && req_ready) lex_request(req);
         if (rsp_valid && rsp_ready) begin
            if (token_queue.size() == 0) begin
               $error("unexpected token kind %0d offset %0d", rsp.token_kind,
                      rsp.token_offset);
               fail_count++;
            end else begin
               e = token_queue.pop_front();
               if (rsp.token_kind !== e.token_kind) begin
                  $error("token_kind exp %0d got %0d", e.token_kind, rsp.token_kind);
                  fail_count++;
               end
               if (rsp.token_offset !== e.token_offset) begin
                  $error("token_offset exp %0d got %0d", e.token_offset, rsp.token_offset);
                  fail_count++;
               end
               if (rsp.token_length !== e.token_length) begin
                  $error("token_length exp %0d got %0d", e.token_length, rsp.token_length);
                  fail_count++;
               end
               if (rsp.error_code !== e.error_code) begin
                  $error("error_code exp %0d got %0d", e.error_code, rsp.error_code);
                  fail_count++;
               end
               if (rsp.end_of_text !== e.end_of_text) begin
                  $error("end_of_text exp %0d got %0d", e.end_of_text, rsp.end_of_text);
                  fail_count++;
               end
               if (rsp.run_last !== e.run_last) begin
                  $error("run_last exp %0d got %0d", e.run_last, rsp.run_last);
                  fail_count++;
               end
            end
         end
         if (idle_cycles >= WatchdogLimit) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // receiver stalls
   initial begin
      int gap;
      @(negedge clock);
      forever begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         @(negedge clock);
      end
   end

   // stimulus
   int sent = 0;

   task automatic send_request(logic [7:0] c, bit fin);
      int gap;
      gap = $urandom_range(0, 4);
      if ($urandom_range(0, 2) == 0) gap = 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req <= '{text_byte: c, final_byte: fin};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      sent++;
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_request(s[i], i == s.len() - 1);
   endtask

   function automatic string rand_token();
      case ($urandom_range(0, 15))
         0: return word_of($urandom_range(0, 5));
         1: return "x_1.a";
         2: return ".fld";
         3: return "12.5";
         4: return "==";
         5: return "=";
         6: return "\"str ing\"";
         7: return "; note";
         8: return "\n\n";
         9: return "  ";
         10: return "()";
         11: return "{}+-,:";
         12: return "abc";
         13: return "_z9";
         14: return "7";
         default: return " ";
      endcase
   endfunction

   initial begin
      string s;
      logic [7:0] c;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      lex_restart();
      // directed part
      foreach (dir_texts[i]) send_text(dir_texts[i]);
      foreach (dir_bytes[i]) send_request(dir_bytes[i][8:1], dir_bytes[i][0]);
      // random texts, mostly well formed
      while (sent < 1600) begin
         s = "";
         repeat ($urandom_range(1, 8)) begin
            s = {s, rand_token()};
            if ($urandom_range(0, 1)) s = {s, " "};
         end
         if ($urandom_range(0, 5) == 0) begin
            c = $urandom_range(0, 255);
            s = {s, string'(c)};
         end
         if ($urandom_range(0, 7) == 0) s = {s, ";", string'(8'($urandom_range(1, 255)))};
         if (s.len() == 0) s = "a";
         send_text(s);
      end
      req_valid <= 1'b0;
      while (token_queue.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/slex_pkg.sv
hw/rtl/slex_scan.sv
hw/rtl/slex_queue.sv
hw/rtl/slex_emit.sv
hw/rtl/script_lexer_top.sv
verif/tb_script_lexer_top.sv
